// ===== rtl/clock_tree_frequency_calc_macros.svh =====
// ----------------------------------------------------------------------------
// clock tree frequency calculator assertion macros
// shared property forms for the concurrent checks of the block
// ----------------------------------------------------------------------------
`ifndef CLOCK_TREE_FREQUENCY_CALC_MACROS_SVH
`define CLOCK_TREE_FREQUENCY_CALC_MACROS_SVH

// same-cycle implication, disabled during reset
`define CTF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ctf_pkg.sv =====
// ----------------------------------------------------------------------------
// clock tree frequency calculator package
// widths, codes, prescaler tables and the sideband record of the pipeline
// ----------------------------------------------------------------------------
package ctf_pkg;

  localparam int OSC_W  = 27;
  localparam int M_W    = 6;
  localparam int N_W    = 9;
  localparam int P_W    = 4;
  localparam int PROD_W = OSC_W + N_W;
  localparam int FREQ_W = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] SRC_INTERNAL = 2'd0;
  localparam logic [1:0] SRC_EXTERNAL = 2'd1;
  localparam logic [1:0] SRC_PLL      = 2'd2;
  localparam logic [1:0] SRC_INVALID  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERNAL_OSC = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTERNAL_OSC = 8'd1;

  localparam logic [OSC_W-1:0] INTERNAL_OSC_RESET = 27'd16000000;
  localparam logic [OSC_W-1:0] EXTERNAL_OSC_RESET = 27'd8000000;

  typedef struct packed {
    logic           bad;
    logic [N_W-1:0] n;
    logic [P_W-1:0] p;
    logic [3:0]     ahb;
    logic [2:0]     apb1;
    logic [2:0]     apb2;
  } ctf_side_t;

  function automatic logic [3:0] ahb_shift(input logic [3:0] code);
    logic [3:0] sh;
    case (code)
      4'd8:    sh = 4'd1;
      4'd9:    sh = 4'd2;
      4'd10:   sh = 4'd3;
      4'd11:   sh = 4'd4;
      4'd12:   sh = 4'd6;
      4'd13:   sh = 4'd7;
      4'd14:   sh = 4'd8;
      4'd15:   sh = 4'd9;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

  function automatic logic [2:0] apb_shift(input logic [2:0] code);
    logic [2:0] sh;
    case (code)
      3'd4:    sh = 3'd1;
      3'd5:    sh = 3'd2;
      3'd6:    sh = 3'd3;
      3'd7:    sh = 3'd4;
      default: sh = 3'd0;
    endcase
    return sh;
  endfunction

  function automatic logic [P_W-1:0] pll_p_div(input logic [1:0] code);
    logic [P_W-1:0] p;
    case (code)
      2'd0:    p = 4'd2;
      2'd1:    p = 4'd4;
      2'd2:    p = 4'd6;
      default: p = 4'd8;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/ctf_div_pipe.sv =====
// ----------------------------------------------------------------------------
// pipelined restoring divider
// unsigned dividend over narrow divisor, BPS quotient bits per register stage
// ----------------------------------------------------------------------------
module ctf_div_pipe import ctf_pkg::*; #(
  parameter int DW  = 27,
  parameter int VW  = 6,
  parameter int BPS = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  ctf_side_t     side_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [DW-1:0] quotient_o,
  output ctf_side_t     side_o
);

  localparam int NS = (DW + BPS - 1) / BPS;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;
  logic [DW-1:0] x_q [NS];
  logic [DW-1:0] x_d [NS];
  logic [VW-1:0] r_q [NS];
  logic [VW-1:0] r_d [NS];
  logic [VW-1:0] d_q [NS];
  ctf_side_t     side_q [NS];

  assign rdy[NS] = out_ready_i;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] x_in;
    logic [VW-1:0] r_in;
    logic [VW-1:0] d_in;
    ctf_side_t     side_in;

    if (s == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign x_in    = dividend_i;
      assign r_in    = '0;
      assign d_in    = divisor_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign x_in    = x_q[s-1];
      assign r_in    = r_q[s-1];
      assign d_in    = d_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign rdy[s] = !v_q[s] | rdy[s+1];

    always_comb begin : p_steps
      logic [VW:0]   t;
      logic [DW-1:0] x;
      logic [VW-1:0] r;
      x = x_in;
      r = r_in;
      for (int k = 0; k < BPS; k++) begin
        if (s * BPS + k < DW) begin
          t = {r, x[DW-1]};
          if (t >= {1'b0, d_in}) begin
            t = t - {1'b0, d_in};
            x = {x[DW-2:0], 1'b1};
          end else begin
            x = {x[DW-2:0], 1'b0};
          end
          r = t[VW-1:0];
        end
      end
      x_d[s] = x;
      r_d[s] = r;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        x_q[s]    <= x_d[s];
        r_q[s]    <= r_d[s];
        d_q[s]    <= d_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign quotient_o  = x_q[NS-1];
  assign side_o      = side_q[NS-1];

endmodule

// ===== rtl/ctf_mul_stage.sv =====
// ----------------------------------------------------------------------------
// pll multiplier stage
// registered product of the divided reference and the feedback multiplier
// ----------------------------------------------------------------------------
module ctf_mul_stage import ctf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OSC_W-1:0]  ref_i,
  input  ctf_side_t         side_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PROD_W-1:0] prod_o,
  output ctf_side_t         side_o
);

  logic              v_q;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] prod_d;
  ctf_side_t         side_q;

  assign in_ready_o = !v_q | out_ready_i;
  assign prod_d     = PROD_W'(ref_i) * PROD_W'(side_i.n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      prod_q <= prod_d;
      side_q <= side_i;
    end
  end

  assign out_valid_o = v_q;
  assign prod_o      = prod_q;
  assign side_o      = side_q;

endmodule

// ===== rtl/ctf_bus_stage.sv =====
// ----------------------------------------------------------------------------
// bus prescaler and output stage
// applies bus and peripheral prescalers, saturates and holds the result
// ----------------------------------------------------------------------------
module ctf_bus_stage import ctf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PROD_W-1:0]   sys_i,
  input  ctf_side_t           side_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [4*FREQ_W-1:0] freq_o,
  output logic                bad_o
);

  function automatic logic [FREQ_W-1:0] sat32(input logic [PROD_W-1:0] v);
    return (|v[PROD_W-1:FREQ_W]) ? '1 : v[FREQ_W-1:0];
  endfunction

  logic                v_q;
  logic [4*FREQ_W-1:0] freq_q;
  logic [4*FREQ_W-1:0] freq_d;
  logic                bad_q;
  logic [PROD_W-1:0]   hclk;
  logic [PROD_W-1:0]   pclk1;
  logic [PROD_W-1:0]   pclk2;

  assign in_ready_o = !v_q | out_ready_i;

  always_comb begin
    hclk  = sys_i >> ahb_shift(side_i.ahb);
    pclk1 = hclk >> apb_shift(side_i.apb1);
    pclk2 = hclk >> apb_shift(side_i.apb2);
    if (side_i.bad) begin
      freq_d = '0;
    end else begin
      freq_d = {sat32(pclk2), sat32(pclk1), sat32(hclk), sat32(sys_i)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      freq_q <= freq_d;
      bad_q  <= side_i.bad;
    end
  end

  assign out_valid_o = v_q;
  assign freq_o      = freq_q;
  assign bad_o       = bad_q;

endmodule

// ===== rtl/clock_tree_frequency_calc.sv =====
// ----------------------------------------------------------------------------
// clock tree frequency calculator
// system, bus and peripheral clock frequencies from clock-control fields
// ----------------------------------------------------------------------------
// channel   dir  transfer when               contents
// s_axis    in   s_axis_tvalid & tready      one set of clock-control fields
// m_axis    out  m_axis_tvalid & tready      four frequencies and error flag
// cfg       in   cfg_valid_i & cfg_ready_o   oscillator frequency registers
//
// one item per cycle while the output is not stalled, through the reference divider
// pipeline, the multiplier stage, the output divider pipeline and the bus stage
// reset clears all stage valid bits and loads 16 MHz and 8 MHz oscillator values
// each stage advances when empty or when the stage after it advances, so
// bubbles close up under a stalled output and nothing is lost or repeated
// ----------------------------------------------------------------------------
module clock_tree_frequency_calc import ctf_pkg::*; #(
  parameter int REF_DIV_BPS = 4,
  parameter int OUT_DIV_BPS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // ahb_code, apb1_code, apb2_code, pll_m, pll_n, pll_p_code, zero fill
  input  logic [31:0]           s_axis_tdata,
  // sys_source, pll_from_external
  input  logic [2:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // sysclk_hz, hclk_hz, pclk1_hz, pclk2_hz
  output logic [4*FREQ_W-1:0]   m_axis_tdata,
  // bad_setting
  output logic [0:0]            m_axis_tuser,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "clock_tree_frequency_calc_macros.svh"

  logic [OSC_W-1:0] internal_osc_q;
  logic [OSC_W-1:0] external_osc_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      internal_osc_q <= INTERNAL_OSC_RESET;
      external_osc_q <= EXTERNAL_OSC_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_INTERNAL_OSC: internal_osc_q <= cfg_data_i[OSC_W-1:0];
        CFG_EXTERNAL_OSC: external_osc_q <= cfg_data_i[OSC_W-1:0];
        default: ;
      endcase
    end
  end

  logic [1:0]       sys_source;
  logic             pll_from_external;
  logic [M_W-1:0]   pll_m;
  logic [N_W-1:0]   pll_n;
  logic [1:0]       pll_p_code;
  logic             use_pll;
  logic [OSC_W-1:0] dividend;
  logic [M_W-1:0]   divisor;
  ctf_side_t        side_in;

  assign sys_source        = s_axis_tuser[1:0];
  assign pll_from_external = s_axis_tuser[2];
  assign pll_m             = s_axis_tdata[15:10];
  assign pll_n             = s_axis_tdata[24:16];
  assign pll_p_code        = s_axis_tdata[26:25];
  assign use_pll           = (sys_source == SRC_PLL);

  // non-pll sources pass through with unit divisors and multiplier
  always_comb begin
    unique case (sys_source)
      SRC_INTERNAL: dividend = internal_osc_q;
      SRC_EXTERNAL: dividend = external_osc_q;
      SRC_PLL:      dividend = pll_from_external ? external_osc_q : internal_osc_q;
      default:      dividend = '0;
    endcase
    divisor      = (use_pll && pll_m != '0) ? pll_m : M_W'(1);
    side_in.bad  = (sys_source == SRC_INVALID) || (use_pll && pll_m == '0);
    side_in.n    = use_pll ? pll_n : N_W'(1);
    side_in.p    = use_pll ? pll_p_div(pll_p_code) : P_W'(1);
    side_in.ahb  = s_axis_tdata[3:0];
    side_in.apb1 = s_axis_tdata[6:4];
    side_in.apb2 = s_axis_tdata[9:7];
  end

  logic              d1_valid;
  logic              d1_ready;
  logic [OSC_W-1:0]  d1_quot;
  ctf_side_t         d1_side;
  logic              mul_valid;
  logic              mul_ready;
  logic [PROD_W-1:0] mul_prod;
  ctf_side_t         mul_side;
  logic              d2_valid;
  logic              d2_ready;
  logic [PROD_W-1:0] d2_quot;
  ctf_side_t         d2_side;

  ctf_div_pipe #(
    .DW  (OSC_W),
    .VW  (M_W),
    .BPS (REF_DIV_BPS)
  ) u_ref_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .dividend_i  (dividend),
    .divisor_i   (divisor),
    .side_i      (side_in),
    .out_valid_o (d1_valid),
    .out_ready_i (d1_ready),
    .quotient_o  (d1_quot),
    .side_o      (d1_side)
  );

  ctf_mul_stage u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d1_valid),
    .in_ready_o  (d1_ready),
    .ref_i       (d1_quot),
    .side_i      (d1_side),
    .out_valid_o (mul_valid),
    .out_ready_i (mul_ready),
    .prod_o      (mul_prod),
    .side_o      (mul_side)
  );

  ctf_div_pipe #(
    .DW  (PROD_W),
    .VW  (P_W),
    .BPS (OUT_DIV_BPS)
  ) u_out_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul_valid),
    .in_ready_o  (mul_ready),
    .dividend_i  (mul_prod),
    .divisor_i   (mul_side.p),
    .side_i      (mul_side),
    .out_valid_o (d2_valid),
    .out_ready_i (d2_ready),
    .quotient_o  (d2_quot),
    .side_o      (d2_side)
  );

  ctf_bus_stage u_bus (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d2_valid),
    .in_ready_o  (d2_ready),
    .sys_i       (d2_quot),
    .side_i      (d2_side),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .freq_o      (m_axis_tdata),
    .bad_o       (m_axis_tuser[0])
  );

  logic [FREQ_W-1:0] out_sys;
  logic [FREQ_W-1:0] out_hclk;
  logic [FREQ_W-1:0] out_pclk1;
  logic [FREQ_W-1:0] out_pclk2;
  logic              out_err;

  assign out_sys   = m_axis_tdata[FREQ_W-1:0];
  assign out_hclk  = m_axis_tdata[2*FREQ_W-1:FREQ_W];
  assign out_pclk1 = m_axis_tdata[3*FREQ_W-1:2*FREQ_W];
  assign out_pclk2 = m_axis_tdata[4*FREQ_W-1:3*FREQ_W];
  assign out_err   = m_axis_tvalid & m_axis_tuser[0];

  `CTF_ASSERT_SAME(a_bad_zero, out_err, m_axis_tdata == '0, "nonzero frequency on error")
  `CTF_ASSERT_SAME(a_hclk_le_sys, m_axis_tvalid, out_hclk <= out_sys, "hclk above sysclk")
  `CTF_ASSERT_SAME(a_pclk1_le_hclk, m_axis_tvalid, out_pclk1 <= out_hclk, "pclk1 above hclk")
  `CTF_ASSERT_SAME(a_pclk2_le_hclk, m_axis_tvalid, out_pclk2 <= out_hclk, "pclk2 above hclk")
  `CTF_ASSERT_SAME(a_ready_when_drained, !m_axis_tvalid, s_axis_tready, "stall with empty output")

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// clock tree frequency calculator testbench
// Sends sets of clock-control fields on the input stream and checks the four
// frequencies and the error flag on the output stream, field by field and in
// order. Expected values come from a short table of hand-worked cases, then
// from a predictor of the clock tree for the remaining table rows and for
// random sets of fields. The oscillator registers are rewritten between
// phases, with the extremes among them. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb import ctf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD   = 10;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          PHASE_ITEMS  = 190;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [1:0] src;
    logic [3:0] ahb;
    logic [2:0] apb1;
    logic [2:0] apb2;
    logic       ext_ref;
    logic [5:0] m;
    logic [8:0] n;
    logic [1:0] pcode;
  } clk_req_t;

  typedef struct packed {
    logic [31:0] sys;
    logic [31:0] hclk;
    logic [31:0] pclk1;
    logic [31:0] pclk2;
    logic        bad;
  } freq_set_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    clk_req_t    req;
    logic        typed;
    freq_set_t   want;
    logic [31:0] int_w;
    logic [31:0] ext_w;
  } stim_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata  = '0;
  logic [2:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [4*FREQ_W-1:0]   m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  logic [OSC_W-1:0] osc_int = INTERNAL_OSC_RESET;
  logic [OSC_W-1:0] osc_ext = EXTERNAL_OSC_RESET;
  logic             steady  = 1'b0;
  freq_set_t        expected_freqs [$];
  stim_row_t        dir_rows [$];
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count    = 0;

  clock_tree_frequency_calc i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 35);
  end

  function automatic logic [31:0] clamp32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic freq_set_t clock_freqs(input clk_req_t r);
    freq_set_t   f;
    logic [63:0] sys;
    logic [63:0] hclk;
    logic [63:0] pll_ref;
    logic [63:0] hshift;
    f   = '0;
    sys = '0;
    case (r.src)
      SRC_INTERNAL: sys = 64'(osc_int);
      SRC_EXTERNAL: sys = 64'(osc_ext);
      SRC_PLL: begin
        if (r.m == '0) begin
          f.bad = 1'b1;
        end else begin
          pll_ref = r.ext_ref ? 64'(osc_ext) : 64'(osc_int);
          sys = (pll_ref / 64'(r.m)) * 64'(r.n) / ((64'(r.pcode) + 64'd1) << 1);
        end
      end
      default: f.bad = 1'b1;
    endcase
    if (!f.bad) begin
      // bus codes 8..11 shift by 1..4, 12..15 by 6..9
      if (r.ahb < 4'd8) hshift = 64'd0;
      else if (r.ahb < 4'd12) hshift = 64'(r.ahb) - 64'd7;
      else hshift = 64'(r.ahb) - 64'd6;
      hclk    = sys >> hshift;
      f.sys   = clamp32(sys);
      f.hclk  = clamp32(hclk);
      f.pclk1 = clamp32(hclk >> (r.apb1[2] ? 64'(r.apb1[1:0]) + 64'd1 : 64'd0));
      f.pclk2 = clamp32(hclk >> (r.apb2[2] ? 64'(r.apb2[1:0]) + 64'd1 : 64'd0));
    end
    return f;
  endfunction

  function automatic clk_req_t req(input logic [1:0] src, input logic [3:0] ahb,
                                  input logic [2:0] apb1, input logic [2:0] apb2,
                                  input logic ext_ref, input logic [5:0] m,
                                  input logic [8:0] n, input logic [1:0] pcode);
    return {src, ahb, apb1, apb2, ext_ref, m, n, pcode};
  endfunction

  function automatic freq_set_t freqs(input logic [31:0] sys, input logic [31:0] hclk,
                                      input logic [31:0] pclk1, input logic [31:0] pclk2,
                                      input logic bad);
    return {sys, hclk, pclk1, pclk2, bad};
  endfunction

  function automatic clk_req_t random_req();
    clk_req_t r;
    r.src     = ($urandom_range(99) < 45) ? SRC_PLL : 2'($urandom_range(3));
    r.ahb     = 4'($urandom);
    r.apb1    = 3'($urandom);
    r.apb2    = 3'($urandom);
    r.ext_ref = 1'($urandom);
    r.m       = ($urandom_range(3) == 0) ? 6'($urandom_range(3)) : 6'($urandom);
    r.n       = 9'($urandom);
    r.pcode   = 2'($urandom);
    return r;
  endfunction

  // random upper bits, which the block must drop
  function automatic logic [31:0] osc_word(input logic [OSC_W-1:0] v);
    return {5'($urandom), v};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 50) begin
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(negedge clk_i) begin
    freq_set_t got;
    freq_set_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
             m_axis_tdata[127:96], m_axis_tuser[0]};
      if (expected_freqs.size() == 0) begin
        report_mismatch("result transfer with none pending", got.sys, 32'd0);
      end else begin
        want = expected_freqs.pop_front();
        check_field("sysclk_hz", got.sys, want.sys);
        check_field("hclk_hz", got.hclk, want.hclk);
        check_field("pclk1_hz", got.pclk1, want.pclk1);
        check_field("pclk2_hz", got.pclk2, want.pclk2);
        check_field("bad_setting", 32'(got.bad), 32'(want.bad));
      end
    end
  end

  task automatic idle_gap();
    while (!steady && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_req(input clk_req_t r, input logic typed, input freq_set_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, r.pcode, r.n, r.m, r.apb2, r.apb1, r.ahb};
    s_axis_tuser  <= {r.ext_ref, r.src};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    expected_freqs.push_back(typed ? want : clock_freqs(r));
    @(posedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_freqs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // both oscillator registers, then one unused index that must be ignored
  task automatic write_osc_regs(input logic [31:0] int_w, input logic [31:0] ext_w);
    for (int k = 0; k < 3; k++) begin
      case (k)
        0: begin
          cfg_index_i <= CFG_INTERNAL_OSC;
          cfg_data_i  <= int_w;
        end
        1: begin
          cfg_index_i <= CFG_EXTERNAL_OSC;
          cfg_data_i  <= ext_w;
        end
        default: begin
          cfg_index_i <= CFG_IDX_W'($urandom_range(255, 2));
          cfg_data_i  <= $urandom;
        end
      endcase
      cfg_valid_i <= 1'b1;
      @(negedge clk_i);
      while (!cfg_ready_o) @(negedge clk_i);
      if (cfg_index_i == CFG_INTERNAL_OSC) osc_int = cfg_data_i[OSC_W-1:0];
      else if (cfg_index_i == CFG_EXTERNAL_OSC) osc_ext = cfg_data_i[OSC_W-1:0];
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    stim_row_t row;

    // reset oscillator values
    dir_rows.push_back({ROW_ITEM, req(SRC_INTERNAL, 0, 0, 0, 0, 1, 1, 0), 1'b1,
      freqs(32'd16000000, 32'd16000000, 32'd16000000, 32'd16000000, 1'b0), 64'd0});
    dir_rows.push_back({ROW_ITEM, req(SRC_EXTERNAL, 0, 0, 0, 1, 0, 0, 0), 1'b1,
      freqs(32'd8000000, 32'd8000000, 32'd8000000, 32'd8000000, 1'b0), 64'd0});
    // zero pll divider ignored off the pll
    dir_rows.push_back({ROW_ITEM, req(SRC_INTERNAL, 7, 3, 3, 1, 0, 511, 3), 1'b1,
      freqs(32'd16000000, 32'd16000000, 32'd16000000, 32'd16000000, 1'b0), 64'd0});
    dir_rows.push_back({ROW_ITEM, req(SRC_INTERNAL, 15, 7, 4, 0, 1, 0, 0), 1'b1,
      freqs(32'd16000000, 32'd31250, 32'd1953, 32'd15625, 1'b0), 64'd0});
    dir_rows.push_back({ROW_ITEM, req(SRC_EXTERNAL, 8, 5, 6, 0, 63, 0, 0), 1'b1,
      freqs(32'd8000000, 32'd4000000, 32'd1000000, 32'd500000, 1'b0), 64'd0});
    // invalid source and zero pll divider
    dir_rows.push_back({ROW_ITEM, req(SRC_INVALID, 15, 7, 7, 1, 63, 511, 3), 1'b1,
      freqs(32'd0, 32'd0, 32'd0, 32'd0, 1'b1), 64'd0});
    dir_rows.push_back({ROW_ITEM, req(SRC_INVALID, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      freqs(32'd0, 32'd0, 32'd0, 32'd0, 1'b1), 64'd0});
    dir_rows.push_back({ROW_ITEM, req(SRC_PLL, 0, 0, 0, 1, 0, 336, 1), 1'b1,
      freqs(32'd0, 32'd0, 32'd0, 32'd0, 1'b1), 64'd0});
    // pll, every output divider
    dir_rows.push_back({ROW_ITEM, req(SRC_PLL, 0, 5, 4, 0, 8, 168, 0), 1'b1,
      freqs(32'd168000000, 32'd168000000, 32'd42000000, 32'd84000000, 1'b0), 64'd0});
    dir_rows.push_back({ROW_ITEM, req(SRC_PLL, 0, 0, 0, 1, 8, 336, 1), 1'b1,
      freqs(32'd84000000, 32'd84000000, 32'd84000000, 32'd84000000, 1'b0), 64'd0});
    dir_rows.push_back({ROW_ITEM, req(SRC_PLL, 0, 0, 0, 0, 16, 192, 2), 1'b1,
      freqs(32'd32000000, 32'd32000000, 32'd32000000, 32'd32000000, 1'b0), 64'd0});
    dir_rows.push_back({ROW_ITEM, req(SRC_PLL, 0, 0, 0, 0, 1, 511, 0), 1'b1,
      freqs(32'd4088000000, 32'd4088000000, 32'd4088000000, 32'd4088000000, 1'b0),
      64'd0});
    dir_rows.push_back({ROW_ITEM, req(SRC_PLL, 15, 7, 7, 1, 5, 0, 3), 1'b1,
      freqs(32'd0, 32'd0, 32'd0, 32'd0, 1'b0), 64'd0});
    dir_rows.push_back({ROW_ITEM, req(SRC_PLL, 10, 6, 5, 1, 63, 511, 3), 1'b0,
      freq_set_t'(0), 64'd0});
    // internal at full scale, external zero, upper data bits dropped
    dir_rows.push_back({ROW_CFG, clk_req_t'(0), 1'b0, freq_set_t'(0),
      32'hFFFF_FFFF, 32'hF800_0000});
    dir_rows.push_back({ROW_ITEM, req(SRC_INTERNAL, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      freqs(32'd134217727, 32'd134217727, 32'd134217727, 32'd134217727, 1'b0), 64'd0});
    dir_rows.push_back({ROW_ITEM, req(SRC_EXTERNAL, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      freqs(32'd0, 32'd0, 32'd0, 32'd0, 1'b0), 64'd0});
    // saturation, with bus clocks divided from the unclamped system clock
    dir_rows.push_back({ROW_ITEM, req(SRC_PLL, 8, 4, 7, 0, 1, 511, 0), 1'b0,
      freq_set_t'(0), 64'd0});
    dir_rows.push_back({ROW_ITEM, req(SRC_PLL, 15, 7, 0, 0, 1, 511, 0), 1'b0,
      freq_set_t'(0), 64'd0});
    dir_rows.push_back({ROW_ITEM, req(SRC_PLL, 12, 5, 6, 0, 63, 511, 3), 1'b0,
      freq_set_t'(0), 64'd0});
    dir_rows.push_back({ROW_ITEM, req(SRC_PLL, 0, 0, 0, 1, 1, 511, 0), 1'b1,
      freqs(32'd0, 32'd0, 32'd0, 32'd0, 1'b0), 64'd0});
    dir_rows.push_back({ROW_CFG, clk_req_t'(0), 1'b0, freq_set_t'(0),
      32'h0000_0000, 32'h07FF_FFFF});
    dir_rows.push_back({ROW_ITEM, req(SRC_PLL, 0, 0, 0, 1, 1, 511, 0), 1'b0,
      freq_set_t'(0), 64'd0});
    dir_rows.push_back({ROW_ITEM, req(SRC_INTERNAL, 15, 7, 7, 0, 0, 0, 0), 1'b1,
      freqs(32'd0, 32'd0, 32'd0, 32'd0, 1'b0), 64'd0});
    dir_rows.push_back({ROW_ITEM, req(SRC_EXTERNAL, 13, 6, 4, 1, 2, 256, 2), 1'b0,
      freq_set_t'(0), 64'd0});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_osc_regs(row.int_w, row.ext_w);
      end else begin
        idle_gap();
        send_req(row.req, row.typed, row.want);
      end
    end

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: write_osc_regs(osc_word(27'($urandom)), osc_word(27'($urandom)));
        1: write_osc_regs(osc_word(27'h7FF_FFFF), osc_word(27'h7FF_FFFF));
        2: write_osc_regs(osc_word(27'd0), osc_word(27'd100000000));
        3: write_osc_regs(osc_word(27'd100000000), osc_word(27'd0));
        default: write_osc_regs(osc_word(INTERNAL_OSC_RESET), osc_word(EXTERNAL_OSC_RESET));
      endcase
      // one phase runs with no idling on either stream
      steady <= (ph == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        idle_gap();
        send_req(random_req(), 1'b0, freq_set_t'(0));
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
